// File: hw/rtl/fca_pkg.sv
// Shared types, codes and constants for the FAT chain allocator.
// No dependencies; used by fat_chain_allocator_core and fca_checker.
package fca_pkg;

  typedef enum logic [2:0] {
    OP_ALLOC  = 3'd0,
    OP_EXTEND = 3'd1,
    OP_READ   = 3'd2,
    OP_FREE   = 3'd3,
    OP_TAIL   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BROKEN = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXT_CHK,
    S_SCAN,
    S_LINK,
    S_WALK
  } state_e;

  localparam logic [7:0] ENTRY_FREE  = 8'd0;
  localparam logic [7:0] ENTRY_BAD   = 8'd254;
  localparam logic [7:0] ENTRY_END   = 8'd255;
  localparam logic [7:0] BAD_BLOCK_A = 8'd13;
  localparam logic [7:0] BAD_BLOCK_B = 8'd49;

  // Table contents right after reset.
  function automatic logic [7:0] reset_entry(input logic [7:0] idx,
                                             input logic [7:0] reserved);
    logic [7:0] val;
    if (idx < reserved) begin
      val = ENTRY_END;
    end else if (idx == BAD_BLOCK_A || idx == BAD_BLOCK_B) begin
      val = ENTRY_BAD;
    end else begin
      val = ENTRY_FREE;
    end
    return val;
  endfunction

endpackage

// File: hw/rtl/fat_chain_allocator_core.sv
// FAT chain allocator: table memory, free-block scan and chain walker.
// Depends on fca_pkg.
//
//  channel  | signals                                          | flow
//  ---------+--------------------------------------------------+-------------------------
//  command  | start, busy, operation_i, block_i                | transfer: start & !busy
//  result   | done_o, result_block_o, entry_value_o,           | one-cycle strobe, no stall
//           | chain_count_o, status_o                          |
//
// Read entry: one table read, then the result. Allocate: scans table entries from
// RESERVED_BLOCKS (at most NUM_BLOCKS - RESERVED_BLOCKS of them); extend adds a
// tail check before the scan and a link write after it, unless the table is full.
// Free chain / find tail: walks one chain block per table read, each read of the
// table memory supplying the next read address.
// Out-of-range and unknown commands answer the next cycle without raising busy.
// Reset is immediate: per-entry valid flags make unwritten entries read as defaults.
module fat_chain_allocator_core #(
  parameter int NUM_BLOCKS      = 128,
  parameter int RESERVED_BLOCKS = 3
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] operation_i,
  input  logic [6:0] block_i,
  output logic       done_o,
  output logic [6:0] result_block_o,
  output logic [7:0] entry_value_o,
  output logic [7:0] chain_count_o,
  output logic [1:0] status_o
);

  localparam int AW = $clog2(NUM_BLOCKS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_BLOCKS - 1);
  localparam logic [AW-1:0] RES_ADDR  = AW'(RESERVED_BLOCKS);
  localparam logic [7:0]    NUM8      = 8'(NUM_BLOCKS);
  localparam logic [7:0]    RES8      = 8'(RESERVED_BLOCKS);

  fca_pkg::state_e state_q, state_d;
  fca_pkg::op_e    op_q, op_d, op_in;

  logic [AW-1:0] link_q, link_d;
  logic [7:0]    n_q, n_d, n_inc;
  logic [AW-1:0] rd_addr_q, ra;

  // table memory plus valid flags and write forwarding
  logic [7:0]    mem [NUM_BLOCKS];
  logic [7:0]    mem_q;
  logic [NUM_BLOCKS-1:0] valid_q;
  logic          vld_rd_q;
  logic          fwd_hit_q;
  logic [7:0]    fwd_data_q;
  logic          we;
  logic [AW-1:0] wa;
  logic [7:0]    wd;
  logic [7:0]    rdata;

  logic                done_q, done_d;
  logic [6:0]          res_blk_q, res_blk_d;
  logic [7:0]          ent_q, ent_d;
  logic [7:0]          cnt_q, cnt_d;
  fca_pkg::status_e    stat_q, stat_d;

  logic [7:0] blk8;
  logic       accept, blk_ok;
  logic       e_bad, e_end, e_free, walk_more;

  assign op_in  = fca_pkg::op_e'(operation_i);
  assign blk8   = {1'b0, block_i};
  assign blk_ok = blk8 < NUM8;
  assign busy   = state_q != fca_pkg::S_IDLE;
  assign accept = start && !busy;

  assign rdata = fwd_hit_q ? fwd_data_q :
                 vld_rd_q  ? mem_q      : fca_pkg::reset_entry(8'(rd_addr_q), RES8);

  assign e_free    = rdata == fca_pkg::ENTRY_FREE;
  assign e_bad     = e_free || rdata == fca_pkg::ENTRY_BAD;
  assign e_end     = rdata == fca_pkg::ENTRY_END;
  assign n_inc     = n_q + 8'd1;
  assign walk_more = !e_bad && !e_end && (n_inc < NUM8) && (rdata < NUM8);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fca_pkg::S_IDLE: begin
        if (accept) begin
          case (op_in)
            fca_pkg::OP_ALLOC:  state_d = fca_pkg::S_SCAN;
            fca_pkg::OP_EXTEND: state_d = blk_ok ? fca_pkg::S_EXT_CHK : fca_pkg::S_IDLE;
            fca_pkg::OP_READ:   state_d = blk_ok ? fca_pkg::S_READ : fca_pkg::S_IDLE;
            fca_pkg::OP_FREE,
            fca_pkg::OP_TAIL:   state_d = blk_ok ? fca_pkg::S_WALK : fca_pkg::S_IDLE;
            default:            state_d = fca_pkg::S_IDLE;
          endcase
        end
      end
      fca_pkg::S_READ:    state_d = fca_pkg::S_IDLE;
      fca_pkg::S_EXT_CHK: state_d = e_end ? fca_pkg::S_SCAN : fca_pkg::S_IDLE;
      fca_pkg::S_SCAN: begin
        if (e_free) begin
          state_d = (op_q == fca_pkg::OP_EXTEND) ? fca_pkg::S_LINK : fca_pkg::S_IDLE;
        end else if (rd_addr_q == LAST_ADDR) begin
          state_d = fca_pkg::S_IDLE;
        end
      end
      fca_pkg::S_LINK:    state_d = fca_pkg::S_IDLE;
      fca_pkg::S_WALK:    state_d = walk_more ? fca_pkg::S_WALK : fca_pkg::S_IDLE;
      default:            state_d = fca_pkg::S_IDLE;
    endcase
  end

  // memory control and result
  always_comb begin
    ra        = rd_addr_q;
    we        = 1'b0;
    wa        = rd_addr_q;
    wd        = fca_pkg::ENTRY_FREE;
    op_d      = op_q;
    link_d    = link_q;
    n_d       = n_q;
    done_d    = 1'b0;
    res_blk_d = '0;
    ent_d     = '0;
    cnt_d     = '0;
    stat_d    = fca_pkg::ST_OK;
    case (state_q)
      fca_pkg::S_IDLE: begin
        if (accept) begin
          op_d   = op_in;
          link_d = blk8[AW-1:0];
          n_d    = '0;
          case (op_in)
            fca_pkg::OP_ALLOC: ra = RES_ADDR;
            fca_pkg::OP_EXTEND,
            fca_pkg::OP_READ,
            fca_pkg::OP_FREE,
            fca_pkg::OP_TAIL: begin
              if (blk_ok) begin
                ra = blk8[AW-1:0];
              end else begin
                done_d = 1'b1;
                stat_d = fca_pkg::ST_BROKEN;
              end
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      fca_pkg::S_READ: begin
        done_d = 1'b1;
        ent_d  = rdata;
      end
      fca_pkg::S_EXT_CHK: begin
        if (e_end) begin
          ra = RES_ADDR;
        end else begin
          done_d = 1'b1;
          stat_d = fca_pkg::ST_BROKEN;
        end
      end
      fca_pkg::S_SCAN: begin
        if (e_free) begin
          // claim it; rd_addr_q holds the block into the link cycle
          we = 1'b1;
          wd = fca_pkg::ENTRY_END;
          if (op_q != fca_pkg::OP_EXTEND) begin
            done_d    = 1'b1;
            res_blk_d = 7'(rd_addr_q);
          end
        end else if (rd_addr_q == LAST_ADDR) begin
          done_d = 1'b1;
          stat_d = fca_pkg::ST_FULL;
        end else begin
          ra = rd_addr_q + AW'(1);
        end
      end
      fca_pkg::S_LINK: begin
        we        = 1'b1;
        wa        = link_q;
        wd        = 8'(rd_addr_q);
        done_d    = 1'b1;
        res_blk_d = 7'(rd_addr_q);
      end
      fca_pkg::S_WALK: begin
        if (e_bad) begin
          done_d = 1'b1;
          stat_d = fca_pkg::ST_BROKEN;
          cnt_d  = n_q;
        end else begin
          we = op_q == fca_pkg::OP_FREE;
          if (e_end) begin
            done_d = 1'b1;
            cnt_d  = n_inc;
            if (op_q == fca_pkg::OP_TAIL) begin
              res_blk_d = 7'(rd_addr_q);
            end
          end else if (!walk_more) begin
            done_d = 1'b1;
            stat_d = fca_pkg::ST_BROKEN;
            cnt_d  = n_inc;
          end else begin
            ra  = rdata[AW-1:0];
            n_d = n_inc;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fca_pkg::S_IDLE;
      done_q  <= 1'b0;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (we) begin
        valid_q[wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    mem_q      <= mem[ra];
    vld_rd_q   <= valid_q[ra];
    fwd_hit_q  <= we && (wa == ra);
    fwd_data_q <= wd;
    rd_addr_q  <= ra;
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    link_q    <= link_d;
    n_q       <= n_d;
    res_blk_q <= res_blk_d;
    ent_q     <= ent_d;
    cnt_q     <= cnt_d;
    stat_q    <= stat_d;
  end

  assign done_o         = done_q;
  assign result_block_o = res_blk_q;
  assign entry_value_o  = ent_q;
  assign chain_count_o  = cnt_q;
  assign status_o       = stat_q;

endmodule

// File: hw/rtl/fca_checker.sv
// Port-level checks for fat_chain_allocator_core, attached by bind.
// Depends on fca_pkg.
module fca_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic [6:0] result_block_o,
  input logic [7:0] entry_value_o,
  input logic [7:0] chain_count_o,
  input logic [1:0] status_o
);

  // a result never shows while a command is still in flight
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // every multi-cycle command ends with a result strobe as busy falls
  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

  // a result only follows a transfer or ongoing work
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_o) |-> ($past(start && !busy) || $past(busy)))
    else $error("result without a command");

  // a full table leaves every other field cleared
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == fca_pkg::ST_FULL) |->
      (result_block_o == 7'd0 && entry_value_o == 8'd0 && chain_count_o == 8'd0))
    else $error("nonzero fields with full status");

endmodule

bind fat_chain_allocator_core fca_checker u_fca_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .done_o         (done_o),
  .result_block_o (result_block_o),
  .entry_value_o  (entry_value_o),
  .chain_count_o  (chain_count_o),
  .status_o       (status_o)
);

// File: test/fat_chain_allocator_core_tb.sv
// Self-checking testbench for fat_chain_allocator_core: directed table rows, then
// random command streams checked against an in-bench model of the allocation table.
// Depends on fca_pkg and the core RTL only.
module fat_chain_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_BLOCKS      = 128;
  localparam int RESERVED_BLOCKS = 3;
  localparam int STALL_LIMIT     = 2000;
  localparam int MAX_REPORTS     = 10;

  // operation codes the core does not decode
  localparam logic [2:0] OP_UNDEF_LO  = 3'd5;
  localparam logic [2:0] OP_UNDEF_MID = 3'd6;
  localparam logic [2:0] OP_UNDEF_HI  = 3'd7;

  typedef struct packed {
    logic [6:0]       blk;
    logic [7:0]       ent;
    logic [7:0]       cnt;
    fca_pkg::status_e st;
  } answer_t;

  typedef struct {
    logic [2:0] op;
    logic [6:0] blk;
    bit         typed;
    answer_t    ans;
  } dir_row_t;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_e;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic [2:0] operation_i;
  logic [6:0] block_i;
  logic       done_o;
  logic [6:0] result_block_o;
  logic [7:0] entry_value_o;
  logic [7:0] chain_count_o;
  logic [1:0] status_o;

  logic [7:0] fat_img [NUM_BLOCKS];
  answer_t    pending_q [$];
  int         chain_heads [$];
  int         errors;
  int         stall_cnt;
  int         n_cmds;
  int         n_full;
  int         n_broken;
  int         n_freed;
  bit         quiet;

  dir_row_t directed_rows [25] = '{
    '{fca_pkg::OP_READ,   7'd0,   1'b1, '{7'd0, 8'd255, 8'd0, fca_pkg::ST_OK}},
    '{fca_pkg::OP_READ,   7'd13,  1'b1, '{7'd0, 8'd254, 8'd0, fca_pkg::ST_OK}},
    '{fca_pkg::OP_READ,   7'd49,  1'b1, '{7'd0, 8'd254, 8'd0, fca_pkg::ST_OK}},
    '{fca_pkg::OP_READ,   7'd127, 1'b1, '{7'd0, 8'd0,   8'd0, fca_pkg::ST_OK}},
    '{fca_pkg::OP_ALLOC,  7'd0,   1'b1, '{7'd3, 8'd0,   8'd0, fca_pkg::ST_OK}},
    '{fca_pkg::OP_EXTEND, 7'd3,   1'b1, '{7'd4, 8'd0,   8'd0, fca_pkg::ST_OK}},
    '{fca_pkg::OP_EXTEND, 7'd4,   1'b1, '{7'd5, 8'd0,   8'd0, fca_pkg::ST_OK}},
    '{fca_pkg::OP_TAIL,   7'd3,   1'b1, '{7'd5, 8'd0,   8'd3, fca_pkg::ST_OK}},
    '{fca_pkg::OP_READ,   7'd3,   1'b0, '{7'd0, 8'd0,   8'd0, fca_pkg::ST_OK}},
    '{fca_pkg::OP_EXTEND, 7'd3,   1'b1, '{7'd0, 8'd0,   8'd0, fca_pkg::ST_BROKEN}},
    '{fca_pkg::OP_EXTEND, 7'd13,  1'b1, '{7'd0, 8'd0,   8'd0, fca_pkg::ST_BROKEN}},
    '{fca_pkg::OP_EXTEND, 7'd6,   1'b1, '{7'd0, 8'd0,   8'd0, fca_pkg::ST_BROKEN}},
    '{fca_pkg::OP_TAIL,   7'd13,  1'b1, '{7'd0, 8'd0,   8'd0, fca_pkg::ST_BROKEN}},
    '{fca_pkg::OP_TAIL,   7'd0,   1'b1, '{7'd0, 8'd0,   8'd1, fca_pkg::ST_OK}},
    '{fca_pkg::OP_FREE,   7'd4,   1'b0, '{7'd0, 8'd0,   8'd0, fca_pkg::ST_OK}},
    '{fca_pkg::OP_TAIL,   7'd3,   1'b0, '{7'd0, 8'd0,   8'd0, fca_pkg::ST_OK}},
    '{fca_pkg::OP_FREE,   7'd3,   1'b0, '{7'd0, 8'd0,   8'd0, fca_pkg::ST_OK}},
    '{fca_pkg::OP_READ,   7'd3,   1'b0, '{7'd0, 8'd0,   8'd0, fca_pkg::ST_OK}},
    '{OP_UNDEF_LO,        7'd127, 1'b1, '{7'd0, 8'd0,   8'd0, fca_pkg::ST_OK}},
    '{OP_UNDEF_MID,       7'd0,   1'b1, '{7'd0, 8'd0,   8'd0, fca_pkg::ST_OK}},
    '{OP_UNDEF_HI,        7'd85,  1'b1, '{7'd0, 8'd0,   8'd0, fca_pkg::ST_OK}},
    '{fca_pkg::OP_FREE,   7'd2,   1'b1, '{7'd0, 8'd0,   8'd1, fca_pkg::ST_OK}},
    '{fca_pkg::OP_EXTEND, 7'd2,   1'b0, '{7'd0, 8'd0,   8'd0, fca_pkg::ST_OK}},
    '{fca_pkg::OP_FREE,   7'd127, 1'b1, '{7'd0, 8'd0,   8'd0, fca_pkg::ST_BROKEN}},
    '{fca_pkg::OP_ALLOC,  7'd0,   1'b0, '{7'd0, 8'd0,   8'd0, fca_pkg::ST_OK}}
  };

  fat_chain_allocator_core #(
    .NUM_BLOCKS      (NUM_BLOCKS),
    .RESERVED_BLOCKS (RESERVED_BLOCKS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .block_i        (block_i),
    .done_o         (done_o),
    .result_block_o (result_block_o),
    .entry_value_o  (entry_value_o),
    .chain_count_o  (chain_count_o),
    .status_o       (status_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic void table_reset();
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      if (i < RESERVED_BLOCKS) begin
        fat_img[i] = fca_pkg::ENTRY_END;
      end else if (i == fca_pkg::BAD_BLOCK_A || i == fca_pkg::BAD_BLOCK_B) begin
        fat_img[i] = fca_pkg::ENTRY_BAD;
      end else begin
        fat_img[i] = fca_pkg::ENTRY_FREE;
      end
    end
  endfunction

  // lowest free non-reserved block, marked end of chain; NUM_BLOCKS when full
  function automatic int take_free_block();
    for (int i = RESERVED_BLOCKS; i < NUM_BLOCKS; i++) begin
      if (fat_img[i] == fca_pkg::ENTRY_FREE) begin
        fat_img[i] = fca_pkg::ENTRY_END;
        return i;
      end
    end
    return NUM_BLOCKS;
  endfunction

  function automatic fca_pkg::status_e walk_chain(input int first, input bit clear,
                                                  output int cnt, output int tail);
    int         cur;
    logic [7:0] e;
    cur  = first;
    cnt  = 0;
    tail = 0;
    while (1'b1) begin
      if (cur >= NUM_BLOCKS) break;
      e = fat_img[cur];
      if (e == fca_pkg::ENTRY_FREE || e == fca_pkg::ENTRY_BAD) break;
      if (clear) fat_img[cur] = fca_pkg::ENTRY_FREE;
      cnt++;
      if (e == fca_pkg::ENTRY_END) begin
        tail = cur;
        return fca_pkg::ST_OK;
      end
      if (cnt >= NUM_BLOCKS) break;
      cur = e;
    end
    tail = 0;
    return fca_pkg::ST_BROKEN;
  endfunction

  // applies one command to the table image and returns the answer it should give
  function automatic answer_t apply_command(input logic [2:0] op, input logic [6:0] blk);
    answer_t a;
    int      nb;
    int      cnt;
    int      tail;
    a    = '0;
    a.st = fca_pkg::ST_OK;
    case (op)
      fca_pkg::OP_ALLOC: begin
        nb = take_free_block();
        if (nb < NUM_BLOCKS) a.blk = nb[6:0];
        else a.st = fca_pkg::ST_FULL;
      end
      fca_pkg::OP_EXTEND: begin
        if (int'(blk) >= NUM_BLOCKS || fat_img[blk] != fca_pkg::ENTRY_END) begin
          a.st = fca_pkg::ST_BROKEN;
        end else begin
          nb = take_free_block();
          if (nb < NUM_BLOCKS) begin
            fat_img[blk] = nb[7:0];
            a.blk        = nb[6:0];
          end else begin
            a.st = fca_pkg::ST_FULL;
          end
        end
      end
      fca_pkg::OP_READ: begin
        if (int'(blk) < NUM_BLOCKS) a.ent = fat_img[blk];
        else a.st = fca_pkg::ST_BROKEN;
      end
      fca_pkg::OP_FREE: begin
        a.st  = walk_chain(blk, 1'b1, cnt, tail);
        a.cnt = cnt[7:0];
      end
      fca_pkg::OP_TAIL: begin
        a.st  = walk_chain(blk, 1'b0, cnt, tail);
        a.cnt = cnt[7:0];
        a.blk = tail[6:0];
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%t mismatch: %s", $realtime, msg);
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // holds one command until its transfer, then records the expected answer
  task automatic issue(input logic [2:0] op, input logic [6:0] blk,
                       input bit typed, input answer_t typed_ans);
    answer_t pred;
    int      g;
    start       <= 1'b1;
    operation_i <= op;
    block_i     <= blk;
    do @(posedge clk_i); while (!(start && !busy));
    pred = apply_command(op, blk);
    pending_q.push_back(typed ? typed_ans : pred);
    n_cmds++;
    if (pred.st == fca_pkg::ST_FULL) n_full++;
    if (pred.st == fca_pkg::ST_BROKEN) n_broken++;
    if (op == fca_pkg::OP_ALLOC && pred.st == fca_pkg::ST_OK)
      chain_heads.push_back(int'(pred.blk));
    if (op == fca_pkg::OP_FREE) begin
      n_freed += pred.cnt;
      for (int i = 0; i < chain_heads.size(); i++) begin
        if (chain_heads[i] == int'(blk)) begin
          chain_heads.delete(i);
          break;
        end
      end
    end
    g = gap_len();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // sender holds off until every outstanding answer is back
  task automatic drain_wait();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_q.size() != 0);
  endtask

  function automatic logic [6:0] some_head();
    if (chain_heads.size() != 0 && $urandom_range(0, 4) != 0)
      return 7'(chain_heads[$urandom_range(0, chain_heads.size() - 1)]);
    return 7'($urandom_range(0, NUM_BLOCKS - 1));
  endfunction

  function automatic logic [6:0] some_tail();
    logic [6:0] h;
    int         cnt;
    int         tail;
    h = some_head();
    if (walk_chain(h, 1'b0, cnt, tail) == fca_pkg::ST_OK) return tail[6:0];
    return h;
  endfunction

  task automatic pick_cmd(input phase_e ph, output logic [2:0] op, output logic [6:0] blk);
    int r;
    r   = $urandom_range(0, 99);
    op  = fca_pkg::OP_READ;
    blk = 7'($urandom_range(0, NUM_BLOCKS - 1));
    case (ph)
      PH_FILL: begin
        if (r < 60) op = fca_pkg::OP_ALLOC;
        else if (r < 85) op = fca_pkg::OP_EXTEND;
        else if (r < 90) op = fca_pkg::OP_TAIL;
        else if (r < 95) op = fca_pkg::OP_READ;
        else op = 3'($urandom_range(0, 7));
      end
      PH_DRAIN: begin
        if (r < 45) op = fca_pkg::OP_FREE;
        else if (r < 55) op = fca_pkg::OP_ALLOC;
        else if (r < 65) op = fca_pkg::OP_EXTEND;
        else if (r < 80) op = fca_pkg::OP_TAIL;
        else if (r < 90) op = fca_pkg::OP_READ;
        else op = 3'($urandom_range(0, 7));
      end
      default: begin
        if (r < 20) op = fca_pkg::OP_ALLOC;
        else if (r < 40) op = fca_pkg::OP_EXTEND;
        else if (r < 55) op = fca_pkg::OP_FREE;
        else if (r < 70) op = fca_pkg::OP_TAIL;
        else if (r < 85) op = fca_pkg::OP_READ;
        else op = 3'($urandom_range(0, 7));
      end
    endcase
    // fill-phase noise keeps its fully random block
    if (r < 95 || ph != PH_FILL) begin
      if (op == fca_pkg::OP_EXTEND && $urandom_range(0, 9) != 0) blk = some_tail();
      else if ((op == fca_pkg::OP_FREE || op == fca_pkg::OP_TAIL) &&
               $urandom_range(0, 9) != 0) blk = some_head();
    end
  endtask

  // result side: the core cannot be stalled, so every strobe is consumed
  always @(posedge clk_i) begin
    answer_t want;
    answer_t got;
    if (rst_ni && done_o) begin
      got = '{result_block_o, entry_value_o, chain_count_o,
              fca_pkg::status_e'(status_o)};
      if (pending_q.size() == 0) begin
        note_error($sformatf("unexpected result blk=%0d ent=%0d cnt=%0d st=%0d",
                             got.blk, got.ent, got.cnt, got.st));
      end else begin
        want = pending_q.pop_front();
        if (got.blk != want.blk || got.ent != want.ent || got.cnt != want.cnt ||
            got.st != want.st) begin
          note_error($sformatf("exp blk=%0d ent=%0d cnt=%0d st=%0d, got blk=%0d ent=%0d cnt=%0d st=%0d",
                               want.blk, want.ent, want.cnt, want.st,
                               got.blk, got.ent, got.cnt, got.st));
        end
      end
    end
  end

  // watchdog: cycles with neither a command transfer nor a result
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", stall_cnt);
      $display("FAIL");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    logic [2:0] op;
    logic [6:0] blk;
    int         per_phase [3];
    start       <= 1'b0;
    operation_i <= fca_pkg::OP_ALLOC;
    block_i     <= '0;
    rst_ni      <= 1'b0;
    errors       = 0;
    stall_cnt    = 0;
    n_cmds       = 0;
    n_full       = 0;
    n_broken     = 0;
    n_freed      = 0;
    quiet        = 1'b0;
    per_phase    = '{200, 100, 150};
    table_reset();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      issue(directed_rows[i].op, directed_rows[i].blk, directed_rows[i].typed,
            directed_rows[i].ans);
    drain_wait();

    for (int ph = PH_FILL; ph <= PH_MIX; ph++) begin
      for (int n = 0; n < per_phase[ph]; n++) begin
        if (n % 32 == 0) quiet = ($urandom_range(0, 3) == 0);
        pick_cmd(phase_e'(ph), op, blk);
        issue(op, blk, 1'b0, '0);
      end
      drain_wait();
    end

    repeat (10) @(posedge clk_i);
    if (pending_q.size() != 0) note_error($sformatf("%0d answers never arrived",
                                                    pending_q.size()));
    $display("%0d commands: %0d on a full table, %0d broken chains, %0d blocks freed",
             n_cmds, n_full, n_broken, n_freed);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/fca_pkg.sv
hw/rtl/fat_chain_allocator_core.sv
hw/rtl/fca_checker.sv
test/fat_chain_allocator_core_tb.sv
